// ===== rtl/core/rrde_pkg.sv =====
// ----------------------------------------------------------------------------
// rrde_pkg: shared definitions for the record ring descriptor engine
// Command and status codes, field widths and the command word passed from
// the front end to the back end.
// ----------------------------------------------------------------------------
package rrde_pkg;

    localparam int DEF_RING_BYTES  = 65536;
    localparam int DEF_MAX_RECORDS = 256;

    localparam int FUNC_W    = 2;
    localparam int LEN_W     = 17;
    localparam int NRI_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int OFF_OUT_W = 16;
    localparam int MINF_W    = 9;
    localparam int FILL_W    = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [MINF_W-1:0] MIN_FILL_RESET = MINF_W'(2);
    localparam logic [MINF_W-1:0] MIN_FILL_LOW   = MINF_W'(2);
    localparam logic [FILL_W-1:0] FILL_MAX       = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ      = 2'd0,
        FUNC_DEQ      = 2'd1,
        FUNC_CLR_FILL = 2'd2,
        FUNC_SET_RD   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_LOW_FILL   = 2'd1,
        ST_BAD_INDEX  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BE_IDLE  = 2'd0,
        BE_ENQ2  = 2'd1,
        BE_DEQ_A = 2'd2,
        BE_DEQ_B = 2'd3
    } back_state_t;

    typedef struct packed {
        func_t             func;
        logic [LEN_W-1:0]  length;
        logic [NRI_W-1:0]  new_read_index;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

// ===== rtl/core/rrde_front.sv =====
// ----------------------------------------------------------------------------
// rrde_front: command intake
// Accepts command words, decodes the function, clamps the record length to
// the ring size and holds the words in a short queue for the back end.
// ----------------------------------------------------------------------------
module rrde_front #(
    parameter int RING_BYTES = rrde_pkg::DEF_RING_BYTES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rrde_pkg::FUNC_W-1:0]  func,
    input  logic [rrde_pkg::LEN_W-1:0]   length,
    input  logic [rrde_pkg::NRI_W-1:0]   new_read_index,
    input  logic                         pop,
    output rrde_pkg::cmd_head_t          head
);

    localparam int QPTR_W = $clog2(rrde_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(rrde_pkg::QUEUE_DEPTH + 1);

    rrde_pkg::cmd_t       q_mem_reg [rrde_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    rrde_pkg::cmd_t       new_cmd;
    logic                 push;
    logic                 do_pop;

    always_comb
    begin
        new_cmd.func           = rrde_pkg::func_t'(func);
        new_cmd.new_read_index = new_read_index;
        // Records longer than the ring occupy the whole ring.
        if (32'(length) > 32'(RING_BYTES))
        begin
            new_cmd.length = rrde_pkg::LEN_W'(RING_BYTES);
        end
        else
        begin
            new_cmd.length = length;
        end
    end

    assign busy   = (count_reg == QCNT_W'(rrde_pkg::QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== rtl/core/rrde_back.sv =====
// ----------------------------------------------------------------------------
// rrde_back: descriptor placement and lookup
// Holds the ring state and the single-port descriptor memory, carries out
// one command word at a time and registers its result.
// ----------------------------------------------------------------------------
module rrde_back #(
    parameter int RING_BYTES  = rrde_pkg::DEF_RING_BYTES,
    parameter int MAX_RECORDS = rrde_pkg::DEF_MAX_RECORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            min_fill_we,
    input  logic [rrde_pkg::MINF_W-1:0]     min_fill,
    input  rrde_pkg::cmd_head_t             head,
    output logic                            pop,
    output logic                            done,
    output logic [rrde_pkg::STATUS_W-1:0]   status,
    output logic [rrde_pkg::OFF_OUT_W-1:0]  first_offset,
    output logic [rrde_pkg::LEN_W-1:0]      first_length,
    output logic [rrde_pkg::OFF_OUT_W-1:0]  second_offset,
    output logic [rrde_pkg::LEN_W-1:0]      second_length,
    output logic                            split
);

    localparam int WO_W  = $clog2(RING_BYTES + 1);
    localparam int OFF_W = $clog2(RING_BYTES);
    localparam int WI_W  = $clog2(MAX_RECORDS + 1);
    localparam int RI_W  = (WI_W > rrde_pkg::NRI_W) ? WI_W : rrde_pkg::NRI_W;
    localparam int AW    = $clog2(MAX_RECORDS);
    localparam int DW    = OFF_W + WO_W + 1;

    localparam logic [WO_W-1:0] RING_END  = WO_W'(RING_BYTES);
    localparam logic [RI_W:0]   RI_LIMIT  = (RI_W + 1)'(MAX_RECORDS);
    localparam logic [WI_W-1:0] WI_LIMIT  = WI_W'(MAX_RECORDS);

    // Descriptor word layout: {lap, length, offset}.
    function automatic logic [OFF_W-1:0] d_off(input logic [DW-1:0] d);
        d_off = d[OFF_W-1:0];
    endfunction

    function automatic logic [WO_W-1:0] d_len(input logic [DW-1:0] d);
        d_len = d[OFF_W+WO_W-1:OFF_W];
    endfunction

    function automatic logic d_lap(input logic [DW-1:0] d);
        d_lap = d[DW-1];
    endfunction

    function automatic logic [WI_W-1:0] next_wr(input logic [WI_W-1:0] idx,
                                                input logic [WI_W-1:0] rl);
        logic [WI_W-1:0] inc;
        inc = idx + WI_W'(1);
        if (rl != '0 && inc == rl)
        begin
            next_wr = '0;
        end
        else
        begin
            next_wr = inc;
        end
    endfunction

    function automatic logic [RI_W-1:0] next_rd(input logic [RI_W-1:0] idx,
                                                input logic [WI_W-1:0] rl);
        logic [RI_W:0] inc;
        inc = {1'b0, idx} + (RI_W + 1)'(1);
        if (rl != '0 && inc == (RI_W + 1)'(rl))
        begin
            next_rd = '0;
        end
        else if (inc >= RI_LIMIT)
        begin
            next_rd = '0;
        end
        else
        begin
            next_rd = inc[RI_W-1:0];
        end
    endfunction

    function automatic logic [RI_W-1:0] behind(input logic [WI_W-1:0] wi,
                                               input logic [rrde_pkg::MINF_W-1:0] mf);
        logic [31:0] d;
        if (32'(wi) > 32'(mf))
        begin
            d = 32'(wi) - 32'(mf);
        end
        else
        begin
            d = '0;
        end
        behind = d[RI_W-1:0];
    endfunction

    function automatic logic [rrde_pkg::OFF_OUT_W-1:0] off_out(input logic [OFF_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        off_out = t[rrde_pkg::OFF_OUT_W-1:0];
    endfunction

    function automatic logic [rrde_pkg::LEN_W-1:0] len_out(input logic [WO_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        len_out = t[rrde_pkg::LEN_W-1:0];
    endfunction

    rrde_pkg::back_state_t          state_reg, state_next;
    logic [WO_W-1:0]                wo_reg, wo_next;
    logic                           lap_reg, lap_next;
    logic                           looped_reg, looped_next;
    logic [WI_W-1:0]                wi_reg, wi_next;
    logic [WI_W-1:0]                rl_reg, rl_next;
    logic [RI_W-1:0]                ri_reg, ri_next;
    logic                           ri_set_reg, ri_set_next;
    logic [rrde_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [rrde_pkg::MINF_W-1:0]    minf_reg, minf_next;
    logic                           done_reg, done_next;

    logic [AW-1:0]                  pend_addr_reg, pend_addr_next;
    logic [DW-1:0]                  pend_data_reg, pend_data_next;
    logic                           ok_a_reg, ok_a_next;
    logic                           ok_b_reg, ok_b_next;
    logic [DW-1:0]                  a_reg, a_next;
    rrde_pkg::status_t              status_reg, status_next;
    logic [OFF_W-1:0]               o1_reg, o1_next;
    logic [WO_W-1:0]                l1_reg, l1_next;
    logic [OFF_W-1:0]               o2_reg, o2_next;
    logic [WO_W-1:0]                l2_reg, l2_next;
    logic                           split_reg, split_next;

    logic [DW-1:0]                  desc_mem [MAX_RECORDS];
    logic [DW-1:0]                  rd_data_reg;
    logic                           mem_we;
    logic [AW-1:0]                  mem_addr;
    logic [DW-1:0]                  mem_wdata;

    logic [31:0]                    len32;
    logic [WO_W-1:0]                enq_len;
    logic                           at_end;
    logic [WO_W-1:0]                wo_eff;
    logic [WO_W:0]                  sum;
    logic                           do_split;
    logic [WO_W-1:0]                rem;
    logic [WO_W-1:0]                len2;
    logic                           table_full;
    logic [WI_W-1:0]                rl_new;
    logic [WI_W-1:0]                wi_mid;
    logic [WI_W-1:0]                hw;
    logic [RI_W-1:0]                ri0;
    logic [RI_W-1:0]                ri1;
    logic [DW-1:0]                  b_desc;
    logic [WO_W:0]                  a_end;

    always_comb
    begin
        len32      = 32'(head.cmd.length);
        enq_len    = len32[WO_W-1:0];
        at_end     = (wo_reg == RING_END);
        wo_eff     = at_end ? '0 : wo_reg;
        sum        = {1'b0, wo_eff} + {1'b0, enq_len};
        do_split   = !at_end && (sum > {1'b0, RING_END});
        rem        = RING_END - wo_reg;
        len2       = enq_len - rem;
        table_full = !looped_reg && (wi_reg == WI_LIMIT);
        rl_new     = looped_reg ? rl_reg : (wi_reg + WI_W'(1));
        wi_mid     = next_wr(wi_reg, rl_new);
        // Entries below this mark have been written since reset; the rest
        // have never been written and are read as zero.
        hw         = looped_reg ? rl_reg : wi_reg;
        ri0        = ri_set_reg ? ri_reg : behind(wi_reg, minf_reg);
        ri1        = next_rd(ri0, rl_reg);
        b_desc     = ok_b_reg ? rd_data_reg : '0;
        a_end      = (WO_W + 1)'(d_off(a_reg)) + (WO_W + 1)'(d_len(a_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        wo_next        = wo_reg;
        lap_next       = lap_reg;
        looped_next    = looped_reg;
        wi_next        = wi_reg;
        rl_next        = rl_reg;
        ri_next        = ri_reg;
        ri_set_next    = ri_set_reg;
        fill_next      = fill_reg;
        minf_next      = minf_reg;
        done_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_data_next = pend_data_reg;
        ok_a_next      = ok_a_reg;
        ok_b_next      = ok_b_reg;
        a_next         = a_reg;
        status_next    = status_reg;
        o1_next        = o1_reg;
        l1_next        = l1_reg;
        o2_next        = o2_reg;
        l2_next        = l2_reg;
        split_next     = split_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = '0;

        if (min_fill_we && min_fill >= rrde_pkg::MIN_FILL_LOW)
        begin
            minf_next = min_fill;
        end

        case (state_reg)
            rrde_pkg::BE_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    done_next   = 1'b1;
                    status_next = rrde_pkg::ST_DONE;
                    o1_next     = '0;
                    l1_next     = '0;
                    o2_next     = '0;
                    l2_next     = '0;
                    split_next  = 1'b0;
                    case (head.cmd.func)
                        rrde_pkg::FUNC_ENQ:
                        begin
                            if (table_full)
                            begin
                                status_next = rrde_pkg::ST_TABLE_FULL;
                            end
                            else
                            begin
                                if (fill_reg != rrde_pkg::FILL_MAX)
                                begin
                                    fill_next = fill_reg + rrde_pkg::FILL_W'(1);
                                end
                                mem_we   = 1'b1;
                                mem_addr = wi_reg[AW-1:0];
                                if (do_split)
                                begin
                                    // The tail goes to the ring end now; the head
                                    // at byte 0 is written in the next cycle.
                                    mem_wdata      = {lap_reg, rem, wo_reg[OFF_W-1:0]};
                                    pend_addr_next = wi_mid[AW-1:0];
                                    pend_data_next = {~lap_reg, len2, {OFF_W{1'b0}}};
                                    lap_next       = ~lap_reg;
                                    looped_next    = 1'b1;
                                    rl_next        = rl_new;
                                    wi_next        = next_wr(wi_mid, rl_new);
                                    wo_next        = len2;
                                    o1_next        = wo_reg[OFF_W-1:0];
                                    l1_next        = rem;
                                    l2_next        = len2;
                                    split_next     = 1'b1;
                                    done_next      = 1'b0;
                                    state_next     = rrde_pkg::BE_ENQ2;
                                end
                                else
                                begin
                                    mem_wdata = {lap_reg, enq_len, wo_eff[OFF_W-1:0]};
                                    wo_next   = wo_eff + enq_len;
                                    wi_next   = next_wr(wi_reg, rl_reg);
                                    o1_next   = wo_eff[OFF_W-1:0];
                                    l1_next   = enq_len;
                                end
                            end
                        end
                        rrde_pkg::FUNC_DEQ:
                        begin
                            if (fill_reg <= rrde_pkg::FILL_W'(minf_reg))
                            begin
                                status_next = rrde_pkg::ST_LOW_FILL;
                            end
                            else
                            begin
                                fill_next   = fill_reg - rrde_pkg::FILL_W'(1);
                                ri_set_next = 1'b1;
                                ri_next     = ri1;
                                mem_addr    = ri0[AW-1:0];
                                ok_a_next   = (ri0 < RI_W'(hw));
                                ok_b_next   = (ri1 < RI_W'(hw));
                                done_next   = 1'b0;
                                state_next  = rrde_pkg::BE_DEQ_A;
                            end
                        end
                        rrde_pkg::FUNC_CLR_FILL:
                        begin
                            fill_next   = '0;
                            ri_next     = behind(wi_reg, minf_reg);
                            ri_set_next = 1'b1;
                        end
                        rrde_pkg::FUNC_SET_RD:
                        begin
                            if (head.cmd.new_read_index == '0)
                            begin
                                status_next = rrde_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                ri_next     = RI_W'(head.cmd.new_read_index);
                                ri_set_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rrde_pkg::BE_ENQ2:
            begin
                mem_we     = 1'b1;
                mem_addr   = pend_addr_reg;
                mem_wdata  = pend_data_reg;
                done_next  = 1'b1;
                state_next = rrde_pkg::BE_IDLE;
            end
            rrde_pkg::BE_DEQ_A:
            begin
                a_next     = ok_a_reg ? rd_data_reg : '0;
                mem_addr   = ri_reg[AW-1:0];
                state_next = rrde_pkg::BE_DEQ_B;
            end
            rrde_pkg::BE_DEQ_B:
            begin
                o1_next = d_off(a_reg);
                l1_next = d_len(a_reg);
                // A record that ends at the ring end and is followed by a
                // descriptor of the other lap was stored as a split pair.
                if (a_end == (WO_W + 1)'(RING_BYTES) && d_lap(a_reg) != d_lap(b_desc))
                begin
                    ri_next    = next_rd(ri_reg, rl_reg);
                    o2_next    = d_off(b_desc);
                    l2_next    = d_len(b_desc);
                    split_next = 1'b1;
                end
                done_next  = 1'b1;
                state_next = rrde_pkg::BE_IDLE;
            end
            default:
            begin
                state_next = rrde_pkg::BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rrde_pkg::BE_IDLE;
            wo_reg     <= '0;
            lap_reg    <= 1'b0;
            looped_reg <= 1'b0;
            wi_reg     <= '0;
            rl_reg     <= '0;
            ri_reg     <= '0;
            ri_set_reg <= 1'b0;
            fill_reg   <= '0;
            minf_reg   <= rrde_pkg::MIN_FILL_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wo_reg     <= wo_next;
            lap_reg    <= lap_next;
            looped_reg <= looped_next;
            wi_reg     <= wi_next;
            rl_reg     <= rl_next;
            ri_reg     <= ri_next;
            ri_set_reg <= ri_set_next;
            fill_reg   <= fill_next;
            minf_reg   <= minf_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        ok_a_reg      <= ok_a_next;
        ok_b_reg      <= ok_b_next;
        a_reg         <= a_next;
        status_reg    <= status_next;
        o1_reg        <= o1_next;
        l1_reg        <= l1_next;
        o2_reg        <= o2_next;
        l2_reg        <= l2_next;
        split_reg     <= split_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            desc_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= desc_mem[mem_addr];
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign first_offset  = off_out(o1_reg);
    assign first_length  = len_out(l1_reg);
    assign second_offset = off_out(o2_reg);
    assign second_length = len_out(l2_reg);
    assign split         = split_reg;

    a_ring_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        looped_reg |-> (rl_reg != '0 && wi_reg < rl_reg))
        else $error("write index outside the fixed descriptor ring");

    a_split_lap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrde_pkg::BE_IDLE && pop && head.cmd.func == rrde_pkg::FUNC_ENQ
         && !table_full && do_split)
        |=> (lap_reg != $past(lap_reg) && state_reg == rrde_pkg::BE_ENQ2))
        else $error("split enqueue did not toggle the lap flag");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != rrde_pkg::ST_DONE)
        |-> (!split_reg && l1_reg == '0 && l2_reg == '0))
        else $error("refused command carries segment data");

    a_deq_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrde_pkg::BE_DEQ_B) |=> (done_reg && state_reg == rrde_pkg::BE_IDLE))
        else $error("dequeue did not deliver its result");

endmodule

// ===== rtl/core/record_ring_descriptor_engine.sv =====
// ----------------------------------------------------------------------------
// record_ring_descriptor_engine: placement engine for a ring of records
// Decides where variable-length records go in a byte ring and hands back
// the segments to copy; the copying itself is done by an external memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (func, length, new_read_index) is taken at a rising edge
//   where start is high and busy is low. busy rises only when the two-entry
//   command queue is full.
//   Every command gives exactly one result word: done is high for one cycle
//   with status and the segment fields. The receiver cannot stall, so the
//   result must be captured in that cycle.
//   Plain enqueues, refusals and the index commands are taken at one command
//   per cycle while the back end is idle; a wrapping enqueue and a served
//   dequeue hold the back end in further states (BE_ENQ2, or BE_DEQ_A and
//   BE_DEQ_B), set by the single port of the descriptor memory (two writes,
//   or two registered reads and the decision).
//   min_fill is written through min_fill_we while the engine is idle; values
//   below two are ignored.
//   After reset the ring is empty, min_fill is two and every descriptor reads
//   as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module record_ring_descriptor_engine #(
    parameter int RING_BYTES  = rrde_pkg::DEF_RING_BYTES,
    parameter int MAX_RECORDS = rrde_pkg::DEF_MAX_RECORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rrde_pkg::FUNC_W-1:0]     func,
    input  logic [rrde_pkg::LEN_W-1:0]      length,
    input  logic [rrde_pkg::NRI_W-1:0]      new_read_index,
    input  logic                            min_fill_we,
    input  logic [rrde_pkg::MINF_W-1:0]     min_fill,
    output logic                            done,
    output logic [rrde_pkg::STATUS_W-1:0]   status,
    output logic [rrde_pkg::OFF_OUT_W-1:0]  first_offset,
    output logic [rrde_pkg::LEN_W-1:0]      first_length,
    output logic [rrde_pkg::OFF_OUT_W-1:0]  second_offset,
    output logic [rrde_pkg::LEN_W-1:0]      second_length,
    output logic                            split
);

    rrde_pkg::cmd_head_t head;
    logic                pop;

    rrde_front #(
        .RING_BYTES(RING_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .length         (length),
        .new_read_index (new_read_index),
        .pop            (pop),
        .head           (head)
    );

    rrde_back #(
        .RING_BYTES  (RING_BYTES),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .min_fill_we   (min_fill_we),
        .min_fill      (min_fill),
        .head          (head),
        .pop           (pop),
        .done          (done),
        .status        (status),
        .first_offset  (first_offset),
        .first_length  (first_length),
        .second_offset (second_offset),
        .second_length (second_length),
        .split         (split)
    );

endmodule

// ===== bench/rrde_segment_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrde_segment_checker: segment predictor and result checker
// Watches the command and result channels of the record ring descriptor
// engine. It keeps its own copy of the ring placement state and descriptor
// table, works out the result word for every accepted command word, and
// compares each result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module rrde_segment_checker #(
    parameter int RING_BYTES  = rrde_pkg::DEF_RING_BYTES,
    parameter int MAX_RECORDS = rrde_pkg::DEF_MAX_RECORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [rrde_pkg::FUNC_W-1:0]     func,
    input  logic [rrde_pkg::LEN_W-1:0]      length,
    input  logic [rrde_pkg::NRI_W-1:0]      new_read_index,
    input  logic                            min_fill_we,
    input  logic [rrde_pkg::MINF_W-1:0]     min_fill,
    input  logic                            done,
    input  logic [rrde_pkg::STATUS_W-1:0]   status,
    input  logic [rrde_pkg::OFF_OUT_W-1:0]  first_offset,
    input  logic [rrde_pkg::LEN_W-1:0]      first_length,
    input  logic [rrde_pkg::OFF_OUT_W-1:0]  second_offset,
    input  logic [rrde_pkg::LEN_W-1:0]      second_length,
    input  logic                            split,
    output int                              pending,
    output int                              errors
);

    typedef struct packed {
        logic [rrde_pkg::OFF_OUT_W-1:0] off;
        logic [rrde_pkg::LEN_W-1:0]     len;
        logic                           lap;
    } slot_t;

    typedef struct packed {
        rrde_pkg::status_t              status;
        logic [rrde_pkg::OFF_OUT_W-1:0] o1;
        logic [rrde_pkg::LEN_W-1:0]     l1;
        logic [rrde_pkg::OFF_OUT_W-1:0] o2;
        logic [rrde_pkg::LEN_W-1:0]     l2;
        logic                           split;
    } seg_result_t;

    slot_t       slots [0:MAX_RECORDS-1];
    seg_result_t pending_segments [$];

    int unsigned wr_off;
    int unsigned wr_idx;
    int unsigned ring_len;
    int unsigned rd_idx;
    int unsigned fill;
    int unsigned min_fill_q;
    logic        lap;
    logic        wrapped;
    logic        rd_chosen;

    initial begin
        errors  = 0;
        pending = 0;
    end

    task automatic clear_model();
        min_fill_q = 32'(rrde_pkg::MIN_FILL_RESET);
        wr_off     = 0;
        wr_idx     = 0;
        ring_len   = 0;
        rd_idx     = 0;
        fill       = 0;
        lap        = 1'b0;
        wrapped    = 1'b0;
        rd_chosen  = 1'b0;
        for (int i = 0; i < MAX_RECORDS; i++)
        begin
            slots[i] = '0;
        end
    endtask

    // Until the first wrap the descriptor index runs freely; afterwards it
    // wraps at the ring length fixed by that wrap.
    function automatic int unsigned step_idx(input int unsigned i);
        i++;
        if (ring_len != 0 && i == ring_len)
        begin
            i = 0;
        end
        return i;
    endfunction

    function automatic int unsigned step_rd(input int unsigned i);
        i = step_idx(i);
        if (i >= MAX_RECORDS)
        begin
            i = 0;
        end
        return i;
    endfunction

    function automatic slot_t fetch_slot(input int unsigned i);
        if (i < MAX_RECORDS)
        begin
            return slots[i];
        end
        return '0;
    endfunction

    function automatic void store_slot(input int unsigned off, input int unsigned len);
        if (wr_idx < MAX_RECORDS)
        begin
            slots[wr_idx].off = off[rrde_pkg::OFF_OUT_W-1:0];
            slots[wr_idx].len = len[rrde_pkg::LEN_W-1:0];
            slots[wr_idx].lap = lap;
        end
    endfunction

    function automatic int unsigned behind_writer();
        return (wr_idx > min_fill_q) ? wr_idx - min_fill_q : 0;
    endfunction

    function automatic seg_result_t segments_for(
        input rrde_pkg::func_t              op,
        input logic [rrde_pkg::LEN_W-1:0]   len_in,
        input logic [rrde_pkg::NRI_W-1:0]   idx_in);
        seg_result_t r;
        int unsigned ln;
        int unsigned rem;
        slot_t       a;
        slot_t       b;
        r  = '0;
        ln = 32'(len_in);
        case (op)
            rrde_pkg::FUNC_ENQ:
            begin
                if (!wrapped && wr_idx >= MAX_RECORDS)
                begin
                    r.status = rrde_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    if (ln > RING_BYTES)
                    begin
                        ln = RING_BYTES;
                    end
                    if (wr_off >= RING_BYTES)
                    begin
                        // Parked exactly at the ring end: restart at zero, same lap.
                        wr_off = 0;
                    end
                    else if (wr_off + ln > RING_BYTES)
                    begin
                        rem = RING_BYTES - wr_off;
                        store_slot(wr_off, rem);
                        r.o1    = wr_off[rrde_pkg::OFF_OUT_W-1:0];
                        r.l1    = rem[rrde_pkg::LEN_W-1:0];
                        r.split = 1'b1;
                        ln      = ln - rem;
                        wr_off  = 0;
                        if (!wrapped)
                        begin
                            ring_len = wr_idx + 1;
                            wrapped  = 1'b1;
                        end
                        lap    = ~lap;
                        wr_idx = step_idx(wr_idx);
                    end
                    store_slot(wr_off, ln);
                    if (r.split)
                    begin
                        r.o2 = wr_off[rrde_pkg::OFF_OUT_W-1:0];
                        r.l2 = ln[rrde_pkg::LEN_W-1:0];
                    end
                    else
                    begin
                        r.o1 = wr_off[rrde_pkg::OFF_OUT_W-1:0];
                        r.l1 = ln[rrde_pkg::LEN_W-1:0];
                    end
                    wr_off = wr_off + ln;
                    wr_idx = step_idx(wr_idx);
                    if (fill < 32'hFFFF)
                    begin
                        fill++;
                    end
                end
            end
            rrde_pkg::FUNC_DEQ:
            begin
                if (fill <= min_fill_q)
                begin
                    r.status = rrde_pkg::ST_LOW_FILL;
                end
                else
                begin
                    if (!rd_chosen)
                    begin
                        rd_idx    = behind_writer();
                        rd_chosen = 1'b1;
                    end
                    fill--;
                    a      = fetch_slot(rd_idx);
                    rd_idx = step_rd(rd_idx);
                    b      = fetch_slot(rd_idx);
                    r.o1   = a.off;
                    r.l1   = a.len;
                    // A segment that ends at the ring end and is followed by one
                    // of the other lap is the first half of a wrapped record.
                    if (32'(a.off) + 32'(a.len) == RING_BYTES && a.lap != b.lap)
                    begin
                        rd_idx  = step_rd(rd_idx);
                        r.o2    = b.off;
                        r.l2    = b.len;
                        r.split = 1'b1;
                    end
                end
            end
            rrde_pkg::FUNC_CLR_FILL:
            begin
                fill      = 0;
                rd_idx    = behind_writer();
                rd_chosen = 1'b1;
            end
            default:
            begin
                if (idx_in == '0)
                begin
                    r.status = rrde_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    rd_idx    = 32'(idx_in);
                    rd_chosen = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        errors++;
        // Keep the log readable when the design is badly broken.
        if (errors <= 100)
        begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        seg_result_t want;
        if (!rst_n)
        begin
            clear_model();
            pending_segments.delete();
        end
        else
        begin
            if (done)
            begin
                if (pending_segments.size() == 0)
                begin
                    report("unexpected result word, status", 32'(status), 0);
                end
                else
                begin
                    want = pending_segments.pop_front();
                    if (status !== want.status)
                        report("status", 32'(status), 32'(want.status));
                    if (first_offset !== want.o1)
                        report("first_offset", 32'(first_offset), 32'(want.o1));
                    if (first_length !== want.l1)
                        report("first_length", 32'(first_length), 32'(want.l1));
                    if (second_offset !== want.o2)
                        report("second_offset", 32'(second_offset), 32'(want.o2));
                    if (second_length !== want.l2)
                        report("second_length", 32'(second_length), 32'(want.l2));
                    if (split !== want.split)
                        report("split", 32'(split), 32'(want.split));
                end
            end
            if (min_fill_we && min_fill >= rrde_pkg::MIN_FILL_LOW)
            begin
                min_fill_q = 32'(min_fill);
            end
            if (start && !busy)
            begin
                pending_segments.insert(pending_segments.size(),
                                        segments_for(rrde_pkg::func_t'(func), length,
                                                     new_read_index));
            end
        end
        pending = pending_segments.size();
    end

endmodule

// ===== bench/tb_record_ring_descriptor_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_ring_descriptor_engine: stimulus and verdict for the ring engine
// Drives a short directed sequence through the ring-end, oversize, wrap and
// refusal cases, then random phases under several min_fill settings, all but
// one with random gaps between command words. A separate checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb_record_ring_descriptor_engine;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [rrde_pkg::FUNC_W-1:0]    func = '0;
    logic [rrde_pkg::LEN_W-1:0]     length = '0;
    logic [rrde_pkg::NRI_W-1:0]     new_read_index = '0;
    logic                           min_fill_we = 1'b0;
    logic [rrde_pkg::MINF_W-1:0]    min_fill = rrde_pkg::MIN_FILL_RESET;
    logic                           done;
    logic [rrde_pkg::STATUS_W-1:0]  status;
    logic [rrde_pkg::OFF_OUT_W-1:0] first_offset;
    logic [rrde_pkg::LEN_W-1:0]     first_length;
    logic [rrde_pkg::OFF_OUT_W-1:0] second_offset;
    logic [rrde_pkg::LEN_W-1:0]     second_length;
    logic                           split;

    int pending;
    int errors;
    int cycles = 0;
    int enq_sent = 0;
    bit idle_on = 1'b1;
    bit fill_mode;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    record_ring_descriptor_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .length         (length),
        .new_read_index (new_read_index),
        .min_fill_we    (min_fill_we),
        .min_fill       (min_fill),
        .done           (done),
        .status         (status),
        .first_offset   (first_offset),
        .first_length   (first_length),
        .second_offset  (second_offset),
        .second_length  (second_length),
        .split          (split)
    );

    rrde_segment_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .length         (length),
        .new_read_index (new_read_index),
        .min_fill_we    (min_fill_we),
        .min_fill       (min_fill),
        .done           (done),
        .status         (status),
        .first_offset   (first_offset),
        .first_length   (first_length),
        .second_offset  (second_offset),
        .second_length  (second_length),
        .split          (split),
        .pending        (pending),
        .errors         (errors)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_record_ring_descriptor_engine: errors");
            $finish;
        end
    end

    // Presents one command word and returns after the edge that took it.
    task automatic issue(input rrde_pkg::func_t op, input logic [rrde_pkg::LEN_W-1:0] ln,
                         input logic [rrde_pkg::NRI_W-1:0] idx);
        while (idle_on && $urandom_range(99) < 24)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        func           <= op;
        length         <= ln;
        new_read_index <= idx;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (op == rrde_pkg::FUNC_ENQ)
        begin
            enq_sent++;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_min_fill(input logic [rrde_pkg::MINF_W-1:0] value);
        drain();
        min_fill_we <= 1'b1;
        min_fill    <= value;
        @(posedge clk);
        min_fill_we <= 1'b0;
    endtask

    // In the overflow run the records must stay short so that the table
    // fills before the byte ring ever wraps.
    function automatic logic [rrde_pkg::LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (fill_mode && enq_sent < 270)
            return rrde_pkg::LEN_W'($urandom_range(200));
        if (r < 3)
            return '0;
        if (r < 28)
            return rrde_pkg::LEN_W'($urandom_range(64, 1));
        if (r < 50)
            return rrde_pkg::LEN_W'($urandom_range(4095, 65));
        if (r < 75)
            return rrde_pkg::LEN_W'($urandom_range(40000, 4096));
        if (r < 93)
            return rrde_pkg::LEN_W'($urandom_range(65536, 40001));
        return rrde_pkg::LEN_W'($urandom_range(131071, 65537));
    endfunction

    function automatic logic [rrde_pkg::NRI_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 75)
            return rrde_pkg::NRI_W'($urandom_range(10, 1));
        return rrde_pkg::NRI_W'($urandom_range(255));
    endfunction

    task automatic run_phase(input int count, input int enq_pct, input int deq_pct,
                             input int set_pct);
        int unsigned r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            // Fields that the command does not use carry random noise.
            if (r < enq_pct)
                issue(rrde_pkg::FUNC_ENQ, pick_length(),
                      rrde_pkg::NRI_W'($urandom_range(255)));
            else if (r < enq_pct + deq_pct)
                issue(rrde_pkg::FUNC_DEQ, rrde_pkg::LEN_W'($urandom_range(131071)),
                      rrde_pkg::NRI_W'($urandom_range(255)));
            else if (r < enq_pct + deq_pct + set_pct)
                issue(rrde_pkg::FUNC_SET_RD, rrde_pkg::LEN_W'($urandom_range(131071)),
                      pick_index());
            else
                issue(rrde_pkg::FUNC_CLR_FILL, rrde_pkg::LEN_W'($urandom_range(131071)),
                      rrde_pkg::NRI_W'($urandom_range(255)));
        end
    endtask

    initial
    begin
        // A table overflow is only possible before the first wrap and it locks
        // out enqueues for good, so each run either overflows or wraps.
        fill_mode = ($urandom_range(3) == 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(rrde_pkg::FUNC_DEQ, '0, '0);                 // nothing buffered yet
        issue(rrde_pkg::FUNC_SET_RD, '0, '0);              // index zero is rejected
        issue(rrde_pkg::FUNC_ENQ, '0, '0);                 // zero-length record
        issue(rrde_pkg::FUNC_ENQ, 17'd1, 8'd255);
        issue(rrde_pkg::FUNC_ENQ, 17'd65535, '0);          // ends exactly at the ring end
        issue(rrde_pkg::FUNC_ENQ, 17'h1FFFF, '0);          // oversized, starts from the end
        issue(rrde_pkg::FUNC_ENQ, 17'd100, '0);
        issue(rrde_pkg::FUNC_DEQ, '0, '0);
        issue(rrde_pkg::FUNC_CLR_FILL, '0, '0);
        issue(rrde_pkg::FUNC_SET_RD, '0, 8'd255);          // beyond anything written
        repeat (3) issue(rrde_pkg::FUNC_ENQ, 17'd64, '0);
        issue(rrde_pkg::FUNC_DEQ, '0, '0);
        if (!fill_mode)
        begin
            issue(rrde_pkg::FUNC_ENQ, 17'd65400, '0);      // first wrap fixes the ring length
            issue(rrde_pkg::FUNC_SET_RD, '0, 8'd8);
            issue(rrde_pkg::FUNC_DEQ, '0, '0);             // returns the joined pair
            issue(rrde_pkg::FUNC_ENQ, 17'd65536, '0);
            issue(rrde_pkg::FUNC_ENQ, 17'd65380, '0);
            issue(rrde_pkg::FUNC_ENQ, 17'd10, '0);
            issue(rrde_pkg::FUNC_SET_RD, '0, 8'd1);
            issue(rrde_pkg::FUNC_DEQ, '0, '0);
        end

        write_min_fill(9'd0);                    // ignored, stays at two
        run_phase(120, 50, 35, 10);
        write_min_fill(9'd3);
        idle_on = 1'b0;
        run_phase(120, 45, 40, 10);
        idle_on = 1'b1;
        write_min_fill(9'd256);
        run_phase(400, 75, 20, 5);
        write_min_fill(9'd511);
        run_phase(60, 50, 40, 5);
        write_min_fill(9'd1);                    // ignored
        write_min_fill(rrde_pkg::MINF_W'($urandom_range(12, 2)));
        run_phase(380, 45, 40, 10);

        drain();
        if (errors == 0)
        begin
            $display("tb_record_ring_descriptor_engine: clean");
        end
        else
        begin
            $display("tb_record_ring_descriptor_engine: errors");
        end
        $finish;
    end

endmodule
